// ===== hw/rtl/rosr_pkg.sv =====
// shared types and constants for the one-shot rtd read sequencer
package rosr_pkg;

  // request codes
  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_SPI_DONE = 2'd1;
  localparam logic [1:0] REQ_TICK = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // result kinds
  localparam logic KIND_SPI = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // status codes
  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_LINK_ERR = 1'b1;

  // configuration register indexes
  localparam logic CFG_FILTER_FIFTY_HZ = 1'b0;
  localparam logic CFG_RC_SETTLE_US = 1'b1;

  localparam int CfgIndexW = 1;
  localparam int CfgDataW = 16;

  typedef struct packed {
    logic        out_kind;
    logic [7:0]  spi_cmd_byte;
    logic [7:0]  spi_data_byte;
    logic        spi_is_read;
    logic [14:0] rtd_value;
    logic        status;
  } rosr_res_t;

  // spi transaction beat: write sets bit 7 of the address byte
  function automatic rosr_res_t spi_beat(input logic [7:0] addr, input logic is_write,
                                         input logic [7:0] data);
    rosr_res_t r;
    r.out_kind      = KIND_SPI;
    r.spi_cmd_byte  = is_write ? ((addr & 8'h7f) | 8'h80) : (addr & 8'h7f);
    r.spi_data_byte = is_write ? data : 8'h00;
    r.spi_is_read   = !is_write;
    r.rtd_value     = 15'd0;
    r.status        = STATUS_OK;
    return r;
  endfunction

endpackage

// ===== hw/rtl/rosr_if.sv =====
// request and result channel interfaces

interface rosr_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] spi_read_data;
  logic       spi_error;

  modport source (output valid, output req_type, output spi_read_data, output spi_error,
                  input ready);
  modport sink (input valid, input req_type, input spi_read_data, input spi_error,
                output ready);
endinterface

interface rosr_res_if;
  logic        valid;
  logic        ready;
  logic        out_kind;
  logic [7:0]  spi_cmd_byte;
  logic [7:0]  spi_data_byte;
  logic        spi_is_read;
  logic [14:0] rtd_value;
  logic        status;

  modport source (output valid, output out_kind, output spi_cmd_byte, output spi_data_byte,
                  output spi_is_read, output rtd_value, output status, input ready);
  modport sink (input valid, input out_kind, input spi_cmd_byte, input spi_data_byte,
                input spi_is_read, input rtd_value, input status, output ready);
endinterface

// ===== hw/rtl/rtd_one_shot_read_sequencer.sv =====
// one-shot rtd read sequencer top level
//
//  channel  dir  beat contents
//  -------  ---  ------------------------------------------------------------
//  req      in   req_type, spi_read_data, spi_error
//  res      out  out_kind, spi_cmd_byte, spi_data_byte, spi_is_read,
//                rtd_value, status
//  cfg      in   cfg_we, cfg_index, cfg_data (write only)
//
// one request beat per cycle while req.ready is high; each beat gives at most one result beat, which
// lands in the result register on the cycle after acceptance
// req.ready is high while the result register is empty or being drained, so
// a stall on res holds off req only while a result actually waits
// rst is synchronous: sequence goes idle, registers take their reset values
module rtd_one_shot_read_sequencer (
  input  logic                                clk,
  input  logic                                rst,
  rosr_req_if.sink                            req,
  rosr_res_if.source                          res,
  input  logic                                cfg_we,
  input  logic [rosr_pkg::CfgIndexW-1:0]      cfg_index,
  input  logic [rosr_pkg::CfgDataW-1:0]       cfg_data
);

  // sequence steps
  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_CLR_RD  = 4'd1;
  localparam logic [3:0] PH_CLR_WR  = 4'd2;
  localparam logic [3:0] PH_BIAS_RD = 4'd3;
  localparam logic [3:0] PH_BIAS_WR = 4'd4;
  localparam logic [3:0] PH_SHOT_RD = 4'd5;
  localparam logic [3:0] PH_SHOT_WR = 4'd6;
  localparam logic [3:0] PH_WAIT    = 4'd7;
  localparam logic [3:0] PH_MSB_RD  = 4'd8;
  localparam logic [3:0] PH_LSB_RD  = 4'd9;
  localparam logic [3:0] PH_OFF_RD  = 4'd10;
  localparam logic [3:0] PH_OFF_WR  = 4'd11;

  // converter register map
  localparam logic [7:0] REG_CFG   = 8'h00;
  localparam logic [7:0] REG_MSB   = 8'h01;
  localparam logic [7:0] REG_LSB   = 8'h02;
  localparam logic [7:0] BIT_BIAS  = 8'h80;
  localparam logic [7:0] BIT_SHOT  = 8'h20;
  localparam logic [7:0] BITS_FDET = 8'h0c;
  localparam logic [7:0] BIT_CLRF  = 8'h02;

  // conversion time in microseconds
  localparam logic [16:0] CONV_US_50HZ = 17'd62500;
  localparam logic [16:0] CONV_US_60HZ = 17'd52000;
  localparam logic [16:0] CEIL_ADD     = 17'd999;
  // floor(x / 1000) = (x * ceil(2^27 / 1000)) >> 27, exact for x < 2^17
  localparam int          RecipShift   = 27;
  localparam logic [17:0] RECIP_1000   = 18'd134218;

  // configuration registers
  logic        filter_fifty_hz;
  logic [15:0] rc_settle_us;

  // sequence state
  logic [3:0] phase, phase_next;
  logic [7:0] config_shadow, config_shadow_next;
  logic [7:0] wait_ticks, wait_ticks_next;
  logic [7:0] rtd_high_byte, rtd_high_byte_next;
  logic [7:0] rtd_low_byte, rtd_low_byte_next;
  logic       saved_error, saved_error_next;

  // result register
  logic                res_valid;
  rosr_pkg::rosr_res_t res_q;

  logic                req_acc;
  logic                emit;
  rosr_pkg::rosr_res_t beat;

  // wait length from current configuration
  logic [16:0] conv_us;
  logic [34:0] conv_prod;
  logic [7:0]  conv_ticks;
  logic [7:0]  wait_dec;
  logic [15:0] rtd_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_fifty_hz <= 1'b0;
      rc_settle_us    <= 16'd10000;
    end else if (cfg_we) begin
      case (cfg_index)
        rosr_pkg::CFG_FILTER_FIFTY_HZ: filter_fifty_hz <= cfg_data[0];
        rosr_pkg::CFG_RC_SETTLE_US:    rc_settle_us    <= cfg_data;
        default: ;
      endcase
    end
  end

  // slot free when empty or draining this cycle
  assign req.ready = !res_valid || res.ready;
  assign req_acc   = req.valid && req.ready;

  always_comb begin
    conv_us    = (filter_fifty_hz ? CONV_US_50HZ : CONV_US_60HZ) + {1'b0, rc_settle_us}
                 + CEIL_ADD;
    conv_prod  = {18'd0, conv_us} * {17'd0, RECIP_1000};
    conv_ticks = conv_prod[RecipShift +: 8];
    wait_dec   = (wait_ticks != 8'd0) ? wait_ticks - 8'd1 : wait_ticks;
    rtd_word   = {rtd_high_byte, rtd_low_byte};
  end

  always_comb begin
    phase_next         = phase;
    config_shadow_next = config_shadow;
    wait_ticks_next    = wait_ticks;
    rtd_high_byte_next = rtd_high_byte;
    rtd_low_byte_next  = rtd_low_byte;
    saved_error_next   = saved_error;
    emit               = 1'b0;
    beat               = rosr_pkg::spi_beat(REG_CFG, 1'b0, 8'h00);

    case (req.req_type)
      rosr_pkg::REQ_START: begin
        // start while busy is dropped
        if (phase == PH_IDLE) begin
          saved_error_next = 1'b0;
          phase_next       = PH_CLR_RD;
          emit             = 1'b1;
          beat             = rosr_pkg::spi_beat(REG_CFG, 1'b0, 8'h00);
        end
      end
      rosr_pkg::REQ_TICK: begin
        if (phase == PH_WAIT) begin
          wait_ticks_next = wait_dec;
          if (wait_dec == 8'd0) begin
            phase_next = PH_MSB_RD;
            emit       = 1'b1;
            beat       = rosr_pkg::spi_beat(REG_MSB, 1'b0, 8'h00);
          end
        end
      end
      rosr_pkg::REQ_SPI_DONE: begin
        // early steps: error ends the run; later steps: error goes to bias-off
        case (phase)
          PH_CLR_RD, PH_CLR_WR, PH_BIAS_RD, PH_BIAS_WR, PH_OFF_RD: begin
            emit = 1'b1;
            if (req.spi_error) begin
              phase_next = PH_IDLE;
              beat = '{out_kind: rosr_pkg::KIND_DONE, spi_cmd_byte: 8'h00,
                       spi_data_byte: 8'h00, spi_is_read: 1'b0, rtd_value: 15'd0,
                       status: rosr_pkg::STATUS_LINK_ERR};
            end else begin
              case (phase)
                PH_CLR_RD: begin
                  config_shadow_next = req.spi_read_data;
                  phase_next         = PH_CLR_WR;
                  beat = rosr_pkg::spi_beat(REG_CFG, 1'b1,
                           (req.spi_read_data & ~(BITS_FDET | BIT_SHOT)) | BIT_CLRF);
                end
                PH_CLR_WR: begin
                  phase_next = PH_BIAS_RD;
                  beat       = rosr_pkg::spi_beat(REG_CFG, 1'b0, 8'h00);
                end
                PH_BIAS_RD: begin
                  config_shadow_next = req.spi_read_data;
                  phase_next         = PH_BIAS_WR;
                  beat = rosr_pkg::spi_beat(REG_CFG, 1'b1, req.spi_read_data | BIT_BIAS);
                end
                PH_BIAS_WR: begin
                  phase_next = PH_SHOT_RD;
                  beat       = rosr_pkg::spi_beat(REG_CFG, 1'b0, 8'h00);
                end
                default: begin
                  // bias-off read done
                  config_shadow_next = req.spi_read_data;
                  phase_next         = PH_OFF_WR;
                  beat = rosr_pkg::spi_beat(REG_CFG, 1'b1, req.spi_read_data & ~BIT_BIAS);
                end
              endcase
            end
          end
          PH_SHOT_RD, PH_SHOT_WR, PH_MSB_RD, PH_LSB_RD: begin
            if (req.spi_error) begin
              saved_error_next = 1'b1;
              phase_next       = PH_OFF_RD;
              emit             = 1'b1;
              beat             = rosr_pkg::spi_beat(REG_CFG, 1'b0, 8'h00);
            end else begin
              case (phase)
                PH_SHOT_RD: begin
                  config_shadow_next = req.spi_read_data;
                  phase_next         = PH_SHOT_WR;
                  emit               = 1'b1;
                  beat = rosr_pkg::spi_beat(REG_CFG, 1'b1, req.spi_read_data | BIT_SHOT);
                end
                PH_SHOT_WR: begin
                  // conversion started: no beat, just arm the wait
                  wait_ticks_next = conv_ticks;
                  phase_next      = PH_WAIT;
                end
                PH_MSB_RD: begin
                  rtd_high_byte_next = req.spi_read_data;
                  phase_next         = PH_LSB_RD;
                  emit               = 1'b1;
                  beat               = rosr_pkg::spi_beat(REG_LSB, 1'b0, 8'h00);
                end
                default: begin
                  rtd_low_byte_next = req.spi_read_data;
                  saved_error_next  = 1'b0;
                  phase_next        = PH_OFF_RD;
                  emit              = 1'b1;
                  beat              = rosr_pkg::spi_beat(REG_CFG, 1'b0, 8'h00);
                end
              endcase
            end
          end
          PH_OFF_WR: begin
            // bias-off write ends every run that got past bias-on, unless the bias-off read fails
            phase_next = PH_IDLE;
            emit       = 1'b1;
            beat.out_kind      = rosr_pkg::KIND_DONE;
            beat.spi_cmd_byte  = 8'h00;
            beat.spi_data_byte = 8'h00;
            beat.spi_is_read   = 1'b0;
            if (saved_error || req.spi_error) begin
              beat.rtd_value = 15'd0;
              beat.status    = rosr_pkg::STATUS_LINK_ERR;
            end else begin
              beat.rtd_value = rtd_word[15:1];
              beat.status    = rosr_pkg::STATUS_OK;
            end
          end
          default: ;  // completion while idle or waiting
        endcase
      end
      default: ;  // unused request code
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      config_shadow <= 8'h00;
      wait_ticks    <= 8'h00;
      rtd_high_byte <= 8'h00;
      rtd_low_byte  <= 8'h00;
      saved_error   <= 1'b0;
    end else if (req_acc) begin
      phase         <= phase_next;
      config_shadow <= config_shadow_next;
      wait_ticks    <= wait_ticks_next;
      rtd_high_byte <= rtd_high_byte_next;
      rtd_low_byte  <= rtd_low_byte_next;
      saved_error   <= saved_error_next;
    end
  end

  // result register: refilled or emptied whenever the slot is free
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (req.ready) begin
      res_valid <= req_acc && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (req_acc && emit) begin
      res_q <= beat;
    end
  end

  assign res.valid         = res_valid;
  assign res.out_kind      = res_q.out_kind;
  assign res.spi_cmd_byte  = res_q.spi_cmd_byte;
  assign res.spi_data_byte = res_q.spi_data_byte;
  assign res.spi_is_read   = res_q.spi_is_read;
  assign res.rtd_value     = res_q.rtd_value;
  assign res.status        = res_q.status;

endmodule

// ===== hw/rtl/rosr_checker.sv =====
// port-level checks for the one-shot rtd read sequencer
module rosr_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic [1:0]  req_type,
  input logic        res_valid,
  input logic        res_ready,
  input logic        out_kind,
  input logic [7:0]  spi_cmd_byte,
  input logic [14:0] rtd_value,
  input logic        status
);

  // a waiting result beat stays up
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result beat dropped while stalled");

  // a waiting result beat holds its command byte, value and status
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(spi_cmd_byte) && $stable(rtd_value) && $stable(status))
    else $error("result payload changed while stalled");

  // an unused request code never causes a result
  assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_type == rosr_pkg::REQ_UNUSED |=> !res_valid)
    else $error("result from unused request code");

  // spi beats carry success status and no value; failed runs report no value
  assert property (@(posedge clk) disable iff (rst)
    res_valid && (out_kind == rosr_pkg::KIND_SPI || status == rosr_pkg::STATUS_LINK_ERR)
      |-> rtd_value == 15'd0 && (out_kind == rosr_pkg::KIND_DONE
                                 || status == rosr_pkg::STATUS_OK))
    else $error("result fields inconsistent with kind and status");

endmodule

bind rtd_one_shot_read_sequencer rosr_checker u_rosr_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .req_type     (req.req_type),
  .res_valid    (res.valid),
  .res_ready    (res.ready),
  .out_kind     (res.out_kind),
  .spi_cmd_byte (res.spi_cmd_byte),
  .rtd_value    (res.rtd_value),
  .status       (res.status)
);
